### rtl/core/lee_pkg.sv
// Shared constants, types and micro-program for the Lorenz Euler stepper.
package lee_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned ProdW       = 2 * DataW;
  localparam int unsigned FracBits    = 20;
  localparam int unsigned StepCntBits = 8;
  localparam int unsigned DtW         = 20;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned UpcW        = 4;

  // last micro-op of one Euler step
  localparam logic [UpcW-1:0] UpcLast = UpcW'(13);

  localparam logic signed [DataW-1:0] SigmaRst  = 32'sd10485760;
  localparam logic signed [DataW-1:0] RhoRst    = 32'sd29360128;
  localparam logic signed [DataW-1:0] BetaRst   = 32'sd2796203;
  localparam logic [DtW-1:0]          DtRst     = 20'd10486;
  localparam logic signed [DataW-1:0] StartXRst = 32'sd1048576;
  localparam logic signed [DataW-1:0] StartYRst = 32'sd0;
  localparam logic signed [DataW-1:0] StartZRst = 32'sd0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SIGMA,
    CFG_RHO,
    CFG_BETA,
    CFG_DT,
    CFG_START_X,
    CFG_START_Y,
    CFG_START_Z
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL
  } op_e;

  typedef enum logic [3:0] {
    SRC_X,
    SRC_Y,
    SRC_Z,
    SRC_S0,
    SRC_S1,
    SRC_DT,
    SRC_SIG,
    SRC_RHO,
    SRC_BETA
  } src_e;

  typedef enum logic [2:0] {
    DST_S0,
    DST_S1,
    DST_NX,
    DST_NY,
    DST_COMMIT
  } dst_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e  op;
    src_e src_a;
    src_e src_b;
    dst_e dst;
  } uop_t;

  typedef struct packed {
    logic signed [DataW-1:0] sigma;
    logic signed [DataW-1:0] rho;
    logic signed [DataW-1:0] beta;
    logic [DtW-1:0]          dt;
    logic signed [DataW-1:0] start_x;
    logic signed [DataW-1:0] start_y;
    logic signed [DataW-1:0] start_z;
  } cfg_t;

  typedef struct packed {
    logic valid;
    op_e  op;
  } alu_req_t;

  typedef struct packed {
    logic valid;
    logic sat;
  } alu_rsp_t;

  // One Euler step, every operation in model order; new x and y are held
  // aside until z is done so all three see the old position.
  function automatic uop_t uop_f(logic [UpcW-1:0] upc);
    uop_t u;
    begin
      case (upc)
        4'd0:    u = '{op: OP_MUL, src_a: SRC_DT,   src_b: SRC_SIG, dst: DST_S0};
        4'd1:    u = '{op: OP_SUB, src_a: SRC_Y,    src_b: SRC_X,   dst: DST_S1};
        4'd2:    u = '{op: OP_MUL, src_a: SRC_S0,   src_b: SRC_S1,  dst: DST_S0};
        4'd3:    u = '{op: OP_ADD, src_a: SRC_X,    src_b: SRC_S0,  dst: DST_NX};
        4'd4:    u = '{op: OP_SUB, src_a: SRC_RHO,  src_b: SRC_Z,   dst: DST_S0};
        4'd5:    u = '{op: OP_MUL, src_a: SRC_X,    src_b: SRC_S0,  dst: DST_S0};
        4'd6:    u = '{op: OP_SUB, src_a: SRC_S0,   src_b: SRC_Y,   dst: DST_S0};
        4'd7:    u = '{op: OP_MUL, src_a: SRC_DT,   src_b: SRC_S0,  dst: DST_S0};
        4'd8:    u = '{op: OP_ADD, src_a: SRC_Y,    src_b: SRC_S0,  dst: DST_NY};
        4'd9:    u = '{op: OP_MUL, src_a: SRC_X,    src_b: SRC_Y,   dst: DST_S0};
        4'd10:   u = '{op: OP_MUL, src_a: SRC_BETA, src_b: SRC_Z,   dst: DST_S1};
        4'd11:   u = '{op: OP_SUB, src_a: SRC_S0,   src_b: SRC_S1,  dst: DST_S0};
        4'd12:   u = '{op: OP_MUL, src_a: SRC_DT,   src_b: SRC_S0,  dst: DST_S0};
        4'd13:   u = '{op: OP_ADD, src_a: SRC_Z,    src_b: SRC_S0,  dst: DST_COMMIT};
        default: u = '{op: OP_ADD, src_a: SRC_S0,   src_b: SRC_S0,  dst: DST_S0};
      endcase
      return u;
    end
  endfunction

endpackage

### rtl/core/lee_in_if.sv
// Request channel: restart flag and step count.
interface lee_in_if import lee_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   restart;
  logic [StepCntBits-1:0] step_count;

  modport source (output valid, restart, step_count, input ready);
  modport sink (input valid, restart, step_count, output ready);
endinterface

### rtl/core/lee_out_if.sv
// Result channel: position after the steps and saturation flag.
interface lee_out_if import lee_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] out_x;
  logic signed [DataW-1:0] out_y;
  logic signed [DataW-1:0] out_z;
  logic                    saturated;

  modport source (output valid, out_x, out_y, out_z, saturated, input ready);
  modport sink (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

### rtl/core/lee_alu.sv
// Shared two-stage fixed-point unit: multiply/add, then scale and saturate.
module lee_alu import lee_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  alu_req_t                req_i,
  input  logic signed [DataW-1:0] opa_i,
  input  logic signed [DataW-1:0] opb_i,
  output alu_rsp_t                rsp_o,
  output logic signed [DataW-1:0] res_o
);

  localparam logic signed [ProdW-1:0] RndBias =
    {{(ProdW-FracBits){1'b0}}, {FracBits{1'b1}}};
  localparam logic signed [ProdW-1:0] MaxV =
    {{(ProdW-DataW+1){1'b0}}, {(DataW-1){1'b1}}};
  localparam logic signed [ProdW-1:0] MinV =
    {{(ProdW-DataW+1){1'b1}}, {(DataW-1){1'b0}}};

  logic signed [ProdW-1:0] raw_d, raw_q, scaled;
  logic                    is_mul_q;
  logic                    valid_q;

  always_comb begin
    case (req_i.op)
      OP_MUL:  raw_d = ProdW'(opa_i) * ProdW'(opb_i);
      OP_ADD:  raw_d = ProdW'(opa_i) + ProdW'(opb_i);
      OP_SUB:  raw_d = ProdW'(opa_i) - ProdW'(opb_i);
      default: raw_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      raw_q    <= raw_d;
      is_mul_q <= (req_i.op == OP_MUL);
    end
  end

  // product scaling truncates toward zero: bias negatives before the shift
  always_comb begin
    if (is_mul_q) begin
      scaled = raw_q[ProdW-1] ? ((raw_q + RndBias) >>> FracBits) : (raw_q >>> FracBits);
    end else begin
      scaled = raw_q;
    end
    rsp_o.valid = valid_q;
    if (scaled > MaxV) begin
      res_o     = MaxV[DataW-1:0];
      rsp_o.sat = 1'b1;
    end else if (scaled < MinV) begin
      res_o     = MinV[DataW-1:0];
      rsp_o.sat = 1'b1;
    end else begin
      res_o     = scaled[DataW-1:0];
      rsp_o.sat = 1'b0;
    end
  end

endmodule

### rtl/core/lee_ctrl.sv
// Sequencer: walks the step micro-program and holds position and scratch.
module lee_ctrl import lee_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    restart_i,
  input  logic [StepCntBits-1:0]  step_count_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DataW-1:0] pos_x_o,
  output logic signed [DataW-1:0] pos_y_o,
  output logic signed [DataW-1:0] pos_z_o,
  output logic                    sat_o,
  output alu_req_t                alu_req_o,
  output logic signed [DataW-1:0] opa_o,
  output logic signed [DataW-1:0] opb_o,
  input  alu_rsp_t                alu_rsp_i,
  input  logic signed [DataW-1:0] alu_res_i
);

  state_e                  state_d, state_q;
  logic [UpcW-1:0]         upc_d, upc_q;
  logic [StepCntBits-1:0]  steps_d, steps_q;
  logic                    sat_d, sat_q;
  logic signed [DataW-1:0] pos_x_d, pos_x_q, pos_y_d, pos_y_q, pos_z_d, pos_z_q;
  logic signed [DataW-1:0] nx_d, nx_q, ny_d, ny_q, s0_d, s0_q, s1_d, s1_q;
  logic signed [DataW-1:0] dt_ext;
  uop_t                    uop;

  assign dt_ext = {{(DataW-DtW){1'b0}}, cfg_i.dt};
  assign uop    = uop_f(upc_q);

  always_comb begin
    case (uop.src_a)
      SRC_X:    opa_o = pos_x_q;
      SRC_Y:    opa_o = pos_y_q;
      SRC_Z:    opa_o = pos_z_q;
      SRC_S0:   opa_o = s0_q;
      SRC_S1:   opa_o = s1_q;
      SRC_DT:   opa_o = dt_ext;
      SRC_SIG:  opa_o = cfg_i.sigma;
      SRC_RHO:  opa_o = cfg_i.rho;
      SRC_BETA: opa_o = cfg_i.beta;
      default:  opa_o = '0;
    endcase
    case (uop.src_b)
      SRC_X:    opb_o = pos_x_q;
      SRC_Y:    opb_o = pos_y_q;
      SRC_Z:    opb_o = pos_z_q;
      SRC_S0:   opb_o = s0_q;
      SRC_S1:   opb_o = s1_q;
      SRC_DT:   opb_o = dt_ext;
      SRC_SIG:  opb_o = cfg_i.sigma;
      SRC_RHO:  opb_o = cfg_i.rho;
      SRC_BETA: opb_o = cfg_i.beta;
      default:  opb_o = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    upc_d       = upc_q;
    steps_d     = steps_q;
    sat_d       = sat_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    pos_z_d     = pos_z_q;
    nx_d        = nx_q;
    ny_d        = ny_q;
    s0_d        = s0_q;
    s1_d        = s1_q;
    alu_req_o   = '{valid: 1'b0, op: uop.op};
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (restart_i) begin
            pos_x_d = cfg_i.start_x;
            pos_y_d = cfg_i.start_y;
            pos_z_d = cfg_i.start_z;
          end
          steps_d = step_count_i;
          upc_d   = '0;
          sat_d   = 1'b0;
          state_d = (step_count_i == '0) ? ST_DONE : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        alu_req_o.valid = 1'b1;
        state_d         = ST_WAIT;
      end
      ST_WAIT: begin
        if (alu_rsp_i.valid) begin
          sat_d = sat_q | alu_rsp_i.sat;
          case (uop.dst)
            DST_S0: s0_d = alu_res_i;
            DST_S1: s1_d = alu_res_i;
            DST_NX: nx_d = alu_res_i;
            DST_NY: ny_d = alu_res_i;
            DST_COMMIT: begin
              pos_x_d = nx_q;
              pos_y_d = ny_q;
              pos_z_d = alu_res_i;
            end
            default: ;
          endcase
          if (upc_q == UpcLast) begin
            upc_d   = '0;
            steps_d = steps_q - StepCntBits'(1);
            state_d = (steps_q == StepCntBits'(1)) ? ST_DONE : ST_ISSUE;
          end else begin
            upc_d   = upc_q + UpcW'(1);
            state_d = ST_ISSUE;
          end
        end
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      upc_q   <= '0;
      steps_q <= '0;
      sat_q   <= 1'b0;
      pos_x_q <= StartXRst;
      pos_y_q <= StartYRst;
      pos_z_q <= StartZRst;
    end else begin
      state_q <= state_d;
      upc_q   <= upc_d;
      steps_q <= steps_d;
      sat_q   <= sat_d;
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      pos_z_q <= pos_z_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q <= nx_d;
    ny_q <= ny_d;
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

  assign pos_x_o = pos_x_q;
  assign pos_y_o = pos_y_q;
  assign pos_z_o = pos_z_q;
  assign sat_o   = sat_q;

endmodule

### rtl/core/lorenz_euler_step.sv
// Lorenz system forward Euler stepper, Q12.20 fixed point, top level.
// Each request word optionally reloads x, y and z from the start registers and
// then runs step_count Euler steps; one result word returns the new position
// and whether any add, subtract or product saturated on the way. Every step is
// fourteen operations on one shared multiply/add unit, each going through the
// unit (multiply or add, then scale and saturate) before the next is issued;
// the block takes no new request until the result word has been taken.
// The configuration port may be written only while the block is idle.
module lorenz_euler_step import lee_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_data_i,
  lee_in_if.sink             in_ch,
  lee_out_if.source          out_ch
);

  cfg_t                    cfg_q;
  alu_req_t                alu_req;
  alu_rsp_t                alu_rsp;
  logic signed [DataW-1:0] opa, opb, alu_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{sigma: SigmaRst, rho: RhoRst, beta: BetaRst, dt: DtRst,
                 start_x: StartXRst, start_y: StartYRst, start_z: StartZRst};
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SIGMA:   cfg_q.sigma   <= cfg_data_i;
        CFG_RHO:     cfg_q.rho     <= cfg_data_i;
        CFG_BETA:    cfg_q.beta    <= cfg_data_i;
        CFG_DT:      cfg_q.dt      <= cfg_data_i[DtW-1:0];
        CFG_START_X: cfg_q.start_x <= cfg_data_i;
        CFG_START_Y: cfg_q.start_y <= cfg_data_i;
        CFG_START_Z: cfg_q.start_z <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lee_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_ch.valid),
    .in_ready_o   (in_ch.ready),
    .restart_i    (in_ch.restart),
    .step_count_i (in_ch.step_count),
    .out_valid_o  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .pos_x_o      (out_ch.out_x),
    .pos_y_o      (out_ch.out_y),
    .pos_z_o      (out_ch.out_z),
    .sat_o        (out_ch.saturated),
    .alu_req_o    (alu_req),
    .opa_o        (opa),
    .opb_o        (opb),
    .alu_rsp_i    (alu_rsp),
    .alu_res_i    (alu_res)
  );

  lee_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .opa_i  (opa),
    .opb_i  (opb),
    .rsp_o  (alu_rsp),
    .res_o  (alu_res)
  );

endmodule

### dv/lorenz_euler_step_test.sv
// Testbench for the Lorenz forward Euler stepper: directed table, then random phases.
module lorenz_euler_step_test import lee_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [DataW-1:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] QMin = 32'sh8000_0000;
  localparam longint                  WordMax = 64'sd2147483647;
  localparam longint                  WordMin = -64'sd2147483648;
  localparam logic [ProdW-1:0]        MagPosMax = 64'h7FFF_FFFF;
  localparam logic [ProdW-1:0]        MagNegMax = 64'h8000_0000;
  localparam logic [CfgIdxW-1:0]      CfgSpare = {CfgIdxW{1'b1}};
  localparam int unsigned             StallLimit = 40000;
  localparam int unsigned             RandPhases = 7;
  localparam int unsigned             PhaseWords = 200;
  localparam int unsigned             HoldCycles = 500;
  localparam int unsigned             ReportMax = 10;

  typedef struct packed {
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] y;
    logic signed [DataW-1:0] z;
    logic                    sat;
  } pos_word_t;

  typedef struct packed {
    logic      pinned;
    pos_word_t want;
  } pin_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic                   restart;
    logic [StepCntBits-1:0] steps;
    logic                   pinned;
    pos_word_t              want;
    logic [CfgIdxW-1:0]     idx;
    logic [DataW-1:0]       data;
  } stim_row_t;

  localparam pos_word_t ResetPos = '{x: StartXRst, y: StartYRst, z: StartZRst, sat: 1'b0};
  localparam pos_word_t ZeroPos  = '{x: '0, y: '0, z: '0, sat: 1'b0};

  logic clk_i;
  logic rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [DataW-1:0]   cfg_data_i;

  lee_in_if  in_ch ();
  lee_out_if out_ch ();

  lorenz_euler_step dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor copy of registers and position
  logic signed [DataW-1:0] m_sigma, m_rho, m_beta, m_sx, m_sy, m_sz;
  logic [DtW-1:0]          m_dt;
  logic signed [DataW-1:0] px, py, pz;
  bit                      step_sat;

  pos_word_t   expected_q[$];
  pin_t        pin_q[$];
  stim_row_t   script_q[$];

  int unsigned n_offered, n_requests, n_results, n_errors, n_saturated, n_writes;
  longint unsigned steps_run;
  int unsigned stall_cycles;
  bit          no_idle;
  bit          hold_done;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [DataW-1:0] sat_word(input logic signed [ProdW-1:0] v);
    if (v > WordMax) begin
      step_sat = 1'b1;
      return QMax;
    end
    if (v < WordMin) begin
      step_sat = 1'b1;
      return QMin;
    end
    return v[DataW-1:0];
  endfunction

  function automatic logic signed [DataW-1:0] q_add(input logic signed [DataW-1:0] a,
                                                    input logic signed [DataW-1:0] b);
    logic signed [ProdW-1:0] wa, wb;
    wa = a;
    wb = b;
    return sat_word(wa + wb);
  endfunction

  function automatic logic signed [DataW-1:0] q_sub(input logic signed [DataW-1:0] a,
                                                    input logic signed [DataW-1:0] b);
    logic signed [ProdW-1:0] wa, wb;
    wa = a;
    wb = b;
    return sat_word(wa - wb);
  endfunction

  // product scaled by FracBits, truncated toward zero, then saturated
  function automatic logic signed [DataW-1:0] q_mul(input logic signed [DataW-1:0] a,
                                                    input logic signed [DataW-1:0] b);
    logic signed [ProdW-1:0] wa, wb, prod;
    logic [ProdW-1:0]        mag, quo;
    wa = a;
    wb = b;
    prod = wa * wb;
    mag = prod[ProdW-1] ? -prod : prod;
    quo = mag >> FracBits;
    if (!prod[ProdW-1]) begin
      if (quo > MagPosMax) begin
        step_sat = 1'b1;
        return QMax;
      end
      return quo[DataW-1:0];
    end
    if (quo > MagNegMax) begin
      step_sat = 1'b1;
      return QMin;
    end
    return -quo[DataW-1:0];
  endfunction

  // all three updates read the old position
  function automatic void euler_step();
    logic signed [DataW-1:0] dtq, t, nx, ny, nz;
    dtq = DataW'(m_dt);
    t  = q_mul(dtq, m_sigma);
    nx = q_add(px, q_mul(t, q_sub(py, px)));
    t  = q_sub(q_mul(px, q_sub(m_rho, pz)), py);
    ny = q_add(py, q_mul(dtq, t));
    t  = q_sub(q_mul(px, py), q_mul(m_beta, pz));
    nz = q_add(pz, q_mul(dtq, t));
    px = nx;
    py = ny;
    pz = nz;
  endfunction

  function automatic pos_word_t advance_position(input logic rs,
                                                 input logic [StepCntBits-1:0] n);
    pos_word_t w;
    if (rs) begin
      px = m_sx;
      py = m_sy;
      pz = m_sz;
    end
    step_sat = 1'b0;
    for (int i = 0; i < int'(n); i++) euler_step();
    w.x = px;
    w.y = py;
    w.z = pz;
    w.sat = step_sat;
    return w;
  endfunction

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin
    pos_word_t got, want;
    pin_t      pin;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        want = advance_position(in_ch.restart, in_ch.step_count);
        steps_run += in_ch.step_count;
        pin = pin_q.pop_front();
        if (pin.pinned) want = pin.want;
        expected_q.push_back(want);
        n_requests++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{x: out_ch.out_x, y: out_ch.out_y, z: out_ch.out_z, sat: out_ch.saturated};
        n_results++;
        if (got.sat) n_saturated++;
        if (expected_q.size() == 0) begin
          n_errors++;
          if (n_errors <= ReportMax)
            $display("%t: result word with nothing expected: x=%0d y=%0d z=%0d sat=%0b",
                     $realtime, got.x, got.y, got.z, got.sat);
        end else begin
          want = expected_q.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
              got.sat !== want.sat) begin
            n_errors++;
            if (n_errors <= ReportMax) begin
              $display("%t: mismatch on result %0d", $realtime, n_results);
              $display("  expected x=%0d y=%0d z=%0d sat=%0b", want.x, want.y, want.z,
                       want.sat);
              $display("  actual   x=%0d y=%0d z=%0d sat=%0b", got.x, got.y, got.z, got.sat);
            end
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  initial begin
    wait (rst_ni === 1'b1);
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("watchdog: no word moved for %0d cycles", StallLimit);
    $display("lorenz_euler_step regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------- result side

  initial begin
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!hold_done && n_requests >= 300) begin
        // long back-pressure: the block holds its result word and stops taking requests
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_ch.ready <= no_idle || ($urandom_range(99) >= 32);
    end
  end

  // ---------------------------------------------------------------- request side

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_SIGMA:   m_sigma = data;
      CFG_RHO:     m_rho   = data;
      CFG_BETA:    m_beta  = data;
      CFG_DT:      m_dt    = data[DtW-1:0];
      CFG_START_X: m_sx    = data;
      CFG_START_Y: m_sy    = data;
      CFG_START_Z: m_sz    = data;
      default: ;
    endcase
    n_writes++;
    @(posedge clk_i);
  endtask

  // wait until every offered word has its result back, then let the block settle
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (n_results != n_offered) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic offer(input logic rs, input logic [StepCntBits-1:0] n,
                       input logic pinned, input pos_word_t want);
    if (cfg_we_i) cfg_we_i <= 1'b0;
    no_idle = (n_offered >= 500 && n_offered < 750);
    while (!no_idle && $urandom_range(99) < 32) begin
      in_ch.valid      <= 1'b0;
      in_ch.restart    <= 1'($urandom_range(1));
      in_ch.step_count <= StepCntBits'($urandom_range(255));
      @(posedge clk_i);
    end
    pin_q.push_back('{pinned: pinned, want: want});
    n_offered++;
    in_ch.valid      <= 1'b1;
    in_ch.restart    <= rs;
    in_ch.step_count <= n;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  function automatic void add_item(input logic rs, input logic [StepCntBits-1:0] n);
    script_q.push_back('{kind: ROW_ITEM, restart: rs, steps: n, pinned: 1'b0, want: ZeroPos,
                         idx: '0, data: '0});
  endfunction

  function automatic void add_pinned(input logic rs, input logic [StepCntBits-1:0] n,
                                     input pos_word_t want);
    script_q.push_back('{kind: ROW_ITEM, restart: rs, steps: n, pinned: 1'b1, want: want,
                         idx: '0, data: '0});
  endfunction

  function automatic void add_cfg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] data);
    script_q.push_back('{kind: ROW_CFG, restart: 1'b0, steps: '0, pinned: 1'b0, want: ZeroPos,
                         idx: idx, data: data});
  endfunction

  function automatic logic [DataW-1:0] pick_q(input int unsigned span);
    case ($urandom_range(9))
      0: return $urandom();
      1: return ($urandom_range(1) != 0) ? QMax : QMin;
      2: return ($urandom_range(1) != 0) ? '0 : '1;
      default: return DataW'(int'($urandom_range(2 * span)) - int'(span));
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_dt();
    case ($urandom_range(9))
      0: return $urandom();  // bits above the dt width must be dropped
      1: return ($urandom_range(1) != 0) ? DataW'({DtW{1'b1}}) : '0;
      default: return DataW'($urandom_range(1, 40000));
    endcase
  endfunction

  function automatic logic [StepCntBits-1:0] pick_steps();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return StepCntBits'($urandom_range(6));
    if (r < 97) return StepCntBits'($urandom_range(24));
    if (r < 99) return StepCntBits'($urandom_range(255));
    return '1;
  endfunction

  initial begin
    pos_word_t none;
    logic [StepCntBits-1:0] n;
    none = ZeroPos;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_SIGMA;
    cfg_data_i       = '0;
    in_ch.valid      = 1'b0;
    in_ch.restart    = 1'b0;
    in_ch.step_count = '0;
    m_sigma = SigmaRst;
    m_rho   = RhoRst;
    m_beta  = BetaRst;
    m_dt    = DtRst;
    m_sx    = StartXRst;
    m_sy    = StartYRst;
    m_sz    = StartZRst;
    px = StartXRst;
    py = StartYRst;
    pz = StartZRst;

    // reset settings
    add_pinned(1'b0, StepCntBits'(0), ResetPos);
    add_pinned(1'b1, StepCntBits'(0), ResetPos);
    add_item(1'b0, StepCntBits'(1));
    add_item(1'b0, StepCntBits'(3));
    add_item(1'b1, StepCntBits'(255));
    add_item(1'b0, StepCntBits'(0));
    // start position at the word limits
    add_cfg(CFG_START_X, QMax);
    add_cfg(CFG_START_Y, QMin);
    add_cfg(CFG_START_Z, QMax);
    add_pinned(1'b1, StepCntBits'(0), '{x: QMax, y: QMin, z: QMax, sat: 1'b0});
    add_item(1'b0, StepCntBits'(1));
    add_item(1'b1, StepCntBits'(2));
    // coefficients at the limits, dt written with all bits set
    add_cfg(CFG_SIGMA, QMin);
    add_cfg(CFG_RHO, QMax);
    add_cfg(CFG_BETA, QMin);
    add_cfg(CFG_DT, '1);
    add_item(1'b1, StepCntBits'(1));
    add_item(1'b0, StepCntBits'(4));
    // zero dt from the origin: nothing moves
    add_cfg(CFG_START_X, '0);
    add_cfg(CFG_START_Y, '0);
    add_cfg(CFG_START_Z, '0);
    add_cfg(CFG_DT, '0);
    add_pinned(1'b1, StepCntBits'(10), ZeroPos);
    add_pinned(1'b0, StepCntBits'(0), ZeroPos);
    // zero dt but y - x overflows
    add_cfg(CFG_START_X, QMin);
    add_cfg(CFG_START_Y, QMax);
    add_item(1'b1, StepCntBits'(3));
    // negative coefficients and the smallest dt, products truncate toward zero
    add_cfg(CFG_SIGMA, -32'sd10485760);
    add_cfg(CFG_RHO, -32'sd29360128);
    add_cfg(CFG_BETA, -32'sd2796203);
    add_cfg(CFG_DT, 32'd1);
    add_cfg(CFG_START_X, -32'sd1048576);
    add_cfg(CFG_START_Y, -32'sd3670016);
    add_cfg(CFG_START_Z, 32'sd2359296);
    add_item(1'b1, StepCntBits'(6));
    add_item(1'b0, StepCntBits'(17));
    // unused index, then back to reset values
    add_cfg(CfgSpare, 32'hA5A5_5A5A);
    add_cfg(CFG_SIGMA, SigmaRst);
    add_cfg(CFG_RHO, RhoRst);
    add_cfg(CFG_BETA, BetaRst);
    add_cfg(CFG_DT, DataW'(DtRst));
    add_cfg(CFG_START_X, StartXRst);
    add_cfg(CFG_START_Y, StartYRst);
    add_cfg(CFG_START_Z, StartZRst);
    add_pinned(1'b1, StepCntBits'(0), ResetPos);
    add_item(1'b0, StepCntBits'(2));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script_q[k]) begin
      if (script_q[k].kind == ROW_CFG) begin
        if (k == 0 || script_q[k-1].kind != ROW_CFG) settle();
        write_reg(script_q[k].idx, script_q[k].data);
      end else begin
        offer(script_q[k].restart, script_q[k].steps, script_q[k].pinned, script_q[k].want);
      end
    end

    for (int ph = 0; ph < int'(RandPhases); ph++) begin
      settle();
      for (int r = 0; r <= int'(CFG_START_Z); r++) begin
        if (ph == 0 || $urandom_range(3) != 0) begin
          case (cfg_idx_e'(r))
            CFG_DT:                              write_reg(CfgIdxW'(r), pick_dt());
            CFG_START_X, CFG_START_Y, CFG_START_Z: write_reg(CfgIdxW'(r), pick_q(16 << FracBits));
            default:                             write_reg(CfgIdxW'(r), pick_q(40 << FracBits));
          endcase
        end
      end
      if ($urandom_range(3) == 0) write_reg(CfgSpare, $urandom());
      offer(1'b1, pick_steps(), 1'b0, none);
      for (int k = 1; k < int'(PhaseWords); k++) begin
        n = pick_steps();
        offer($urandom_range(3) == 0, n, 1'b0, none);
      end
    end

    in_ch.valid <= 1'b0;
    while (n_results != n_offered) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    n_errors += expected_q.size();

    $display("ran %0d requests (%0d Euler steps in all) over %0d register writes,",
             n_requests, steps_run, n_writes);
    $display("checked %0d results, %0d of them saturated, %0d errors",
             n_results, n_saturated, n_errors);
    if (n_errors == 0) $display("lorenz_euler_step regression: pass");
    else $display("lorenz_euler_step regression: fail");
    $finish;
  end

endmodule
